### src/flow_controlled_byte_fifo_top_defines.svh
// Assertion macros shared by the byte FIFO modules.
`ifndef FLOW_CONTROLLED_BYTE_FIFO_TOP_DEFINES_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define FCBF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("fcbf: invariant violated");

// consequent must hold in the cycle after antecedent
`define FCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fcbf: sequence violated");

`endif

### src/fcbf_pkg.sv
// Types and constants of the byte FIFO.
`default_nettype none
package fcbf_pkg;

    localparam int CFG_W   = 11;
    localparam int CNT_OUT = 11;
    localparam int TOT_W   = 64;
    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_END   = 2'd3
    } t_action;

    typedef struct packed {
        logic               write_accepted;
        logic [CNT_OUT-1:0] fill_count;
        logic [CNT_OUT-1:0] space_left;
        logic [TOT_W-1:0]   total_written;
        logic [TOT_W-1:0]   total_read;
        logic               input_done;
        logic               is_empty;
        logic               at_eof;
    } t_status;

    typedef struct packed {
        logic     wr_en;
        logic     rd_en;
        logic [7:0] wdata;
        t_status  status;
    } t_cmd;

endpackage
`default_nettype wire

### src/fcbf_if.sv
// Input and result channel interfaces of the byte FIFO.
`default_nettype none
interface fcbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [9:0]  peek_offset;

    modport source (output valid, action, data_byte, peek_offset, input ready);
    modport sink   (input valid, action, data_byte, peek_offset, output ready);
endinterface

interface fcbf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        write_accepted;
    logic [10:0] fill_count;
    logic [10:0] space_left;
    logic [63:0] total_written;
    logic [63:0] total_read;
    logic        input_done;
    logic        is_empty;
    logic        at_eof;

    modport source (output valid, out_byte, out_valid, write_accepted, fill_count,
                    space_left, total_written, total_read, input_done, is_empty,
                    at_eof, input ready);
    modport sink   (input valid, out_byte, out_valid, write_accepted, fill_count,
                    space_left, total_written, total_read, input_done, is_empty,
                    at_eof, output ready);
endinterface
`default_nettype wire

### src/fcbf_front.sv
// Front end: accepts items, tracks pointers, fill and totals, issues store commands.
`default_nettype none
`include "flow_controlled_byte_fifo_top_defines.svh"
module fcbf_front
    import fcbf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_W-1:0]         i_cfg_wdata,
    fcbf_in_if.sink                       i_in,
    input  wire logic                     i_q_ready,
    output      logic                     o_push,
    output      t_cmd                     o_cmd,
    output      logic [$clog2(DEPTH)-1:0] o_addr
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam int OW = ((AW > 10) ? AW : 10) + 1;

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [TOT_W-1:0] r_wtot, n_wtot;
    logic [TOT_W-1:0] r_rtot, n_rtot;
    logic             r_ended, n_ended;
    logic [XW-1:0]    r_cap;

    logic             accept;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    ncnt_x;
    logic [XW-1:0]    off_x;
    logic [XW-1:0]    cfg_x;
    logic [OW-1:0]    peek_sum;
    logic [AW-1:0]    peek_addr;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    tail_inc;
    logic             at_bound;

    assign accept  = i_in.valid & i_q_ready;
    assign i_in.ready = i_q_ready;
    assign o_push  = accept;

    assign cnt_x   = XW'(r_count);
    assign off_x   = XW'(i_in.peek_offset);
    assign cfg_x   = XW'(i_cfg_wdata);
    assign peek_sum = OW'(r_head) + OW'(i_in.peek_offset);
    assign peek_addr = (peek_sum >= OW'(DEPTH)) ? AW'(peek_sum - OW'(DEPTH)) : AW'(peek_sum);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign at_bound = (r_count == '0) || (r_count == CW'(DEPTH));

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_wtot  = r_wtot;
        n_rtot  = r_rtot;
        n_ended = r_ended;
        o_cmd.wr_en = 1'b0;
        o_cmd.rd_en = 1'b0;
        o_cmd.wdata = i_in.data_byte;
        o_addr      = r_tail;
        case (t_action'(i_in.action))
            ACT_WRITE: begin
                if (cnt_x < r_cap) begin
                    o_cmd.wr_en = 1'b1;
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                    n_wtot  = r_wtot + 1'b1;
                end
            end
            ACT_READ: begin
                o_addr = r_head;
                if (r_count != '0) begin
                    o_cmd.rd_en = 1'b1;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    n_rtot  = r_rtot + 1'b1;
                end
            end
            ACT_PEEK: begin
                o_addr = peek_addr;
                if (off_x < cnt_x) begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            ACT_END: begin
                n_ended = 1'b1;
            end
            default: begin
                n_ended = r_ended;
            end
        endcase

        // totals differ by exactly the fill, so they match when the FIFO is empty
        ncnt_x = XW'(n_count);
        o_cmd.status.write_accepted = o_cmd.wr_en;
        o_cmd.status.fill_count     = CNT_OUT'(n_count);
        o_cmd.status.space_left     = (r_cap > ncnt_x) ? CNT_OUT'(r_cap - ncnt_x) : '0;
        o_cmd.status.total_written  = n_wtot;
        o_cmd.status.total_read     = n_rtot;
        o_cmd.status.input_done     = n_ended;
        o_cmd.status.is_empty       = (n_count == '0);
        o_cmd.status.at_eof         = n_ended & (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_wtot  <= '0;
            r_rtot  <= '0;
            r_ended <= 1'b0;
            r_cap   <= (XW'(CAP_RESET) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(CAP_RESET);
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_wtot  <= n_wtot;
                r_rtot  <= n_rtot;
                r_ended <= n_ended;
            end
            if (i_cfg_we) begin
                r_cap <= (cfg_x > XW'(DEPTH)) ? XW'(DEPTH) : cfg_x;
            end
        end
    end

    `FCBF_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `FCBF_ASSERT_ALWAYS(a_ptr_match, i_clk, i_rst_n, (r_head == r_tail) == at_bound)
    `FCBF_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !accept, $stable(r_count) && $stable(r_head) && $stable(r_tail))

endmodule
`default_nettype wire

### src/fcbf_queue.sv
// Two-entry command queue between front and back end.
`default_nettype none
`include "flow_controlled_byte_fifo_top_defines.svh"
module fcbf_queue
    import fcbf_pkg::*;
#(
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_addr,
    output      logic          o_ready,
    input  wire logic          i_pop,
    output      logic          o_valid,
    output      t_cmd          o_cmd,
    output      logic [AW-1:0] o_addr
);
    t_cmd          r_cmd  [2];
    logic [AW-1:0] r_addr [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_push & o_ready;
    assign pop     = i_pop & o_valid;
    assign o_cmd   = r_cmd[r_rptr];
    assign o_addr  = r_addr[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wptr]  <= i_cmd;
            r_addr[r_wptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `FCBF_ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
    `FCBF_ASSERT_NEXT(a_q_grow, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 2'd1)
    `FCBF_ASSERT_NEXT(a_q_drain, i_clk, i_rst_n, pop && !push, r_cnt == $past(r_cnt) - 2'd1)

endmodule
`default_nettype wire

### src/fcbf_back.sv
// Back end: byte store, store access and result register.
`default_nettype none
module fcbf_back
    import fcbf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire t_cmd                     i_cmd,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    output      logic                     o_pop,
    fcbf_out_if.source                    o_out
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic       r_rd;
    t_status    r_status;
    logic       r_vld;
    logic       pop;

    assign pop   = i_valid & (~r_vld | o_out.ready);
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_cmd.wr_en) begin
                r_mem[i_addr] <= i_cmd.wdata;
            end
            r_rdata  <= r_mem[i_addr];
            r_rd     <= i_cmd.rd_en;
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (pop) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    assign o_out.valid          = r_vld;
    assign o_out.out_byte       = r_rd ? r_rdata : 8'd0;
    assign o_out.out_valid      = r_rd;
    assign o_out.write_accepted = r_status.write_accepted;
    assign o_out.fill_count     = r_status.fill_count;
    assign o_out.space_left     = r_status.space_left;
    assign o_out.total_written  = r_status.total_written;
    assign o_out.total_read     = r_status.total_read;
    assign o_out.input_done     = r_status.input_done;
    assign o_out.is_empty       = r_status.is_empty;
    assign o_out.at_eof         = r_status.at_eof;

endmodule
`default_nettype wire

### src/flow_controlled_byte_fifo_top.sv
// Byte FIFO with settable capacity: one item in, one result out.
// An accepted item passes through the command queue and then the result register.
// Throughput: one item per cycle unless back-pressure fills the queue; the front
// state update and the single store port each handle one access a cycle. Reset
// clears pointers, fill, totals and end flag and sets capacity to 1024 or DEPTH
// if smaller; store contents are undefined until written, with no clearing pass.
`default_nettype none
module flow_controlled_byte_fifo_top
    import fcbf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    fcbf_in_if.sink               i_in,
    fcbf_out_if.source            o_out
);
    localparam int AW = $clog2(DEPTH);

    logic          f_push;
    t_cmd          f_cmd;
    logic [AW-1:0] f_addr;
    logic          q_ready;
    logic          q_valid;
    t_cmd          q_cmd;
    logic [AW-1:0] q_addr;
    logic          b_pop;

    fcbf_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_ready   (q_ready),
        .o_push      (f_push),
        .o_cmd       (f_cmd),
        .o_addr      (f_addr)
    );

    fcbf_queue #(.AW(AW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .o_ready (q_ready),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr)
    );

    fcbf_back #(.DEPTH(DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .i_addr  (q_addr),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
